FILE: rtl/swt_pkg.sv
// ----------------------------------------------------------------------------
// swt_pkg
// Shared types and constants of the sorted watchpoint table.
// ----------------------------------------------------------------------------
package swt_pkg;

  localparam int TABLE_DEPTH = 32;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam int ADDR_W      = 24;
  localparam int SPAN_W      = 16;
  localparam int KIND_W      = 5;
  localparam int OP_W        = 3;
  localparam int HIDX_W      = 5;
  localparam int TOTAL_W     = 6;
  localparam int SUM_W       = ADDR_W + 1;

  localparam logic [ADDR_W-1:0] ADDR_MAX = '1;

  localparam logic [KIND_W-1:0] K_WRITE  = 5'b00100;
  localparam logic [KIND_W-1:0] K_READ   = 5'b01000;
  localparam logic [KIND_W-1:0] K_ACCESS = 5'b10000;

  typedef enum logic [OP_W-1:0] {
    OP_SET    = 3'd0,
    OP_REMOVE = 3'd1,
    OP_CLEAR  = 3'd2,
    OP_LOOKUP = 3'd3,
    OP_RANGE  = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_LIMIT     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    RSN_ACCESS = 2'd0,
    RSN_WRITE  = 2'd1,
    RSN_READ   = 2'd2
  } reason_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [SPAN_W-1:0] span;
    logic [KIND_W-1:0] kinds;
  } entry_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

endpackage

FILE: rtl/swt_ram.sv
// ----------------------------------------------------------------------------
// swt_ram
// Entry store: one write port and one registered read port.
// ----------------------------------------------------------------------------
module swt_ram
  import swt_pkg::*;
(
  input  logic     clk,
  input  mem_req_t req,
  output entry_t   rdata
);

  entry_t mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

FILE: rtl/swt_ctrl.sv
// ----------------------------------------------------------------------------
// swt_ctrl
// Sequencer: scans the entry store, merges or inserts, shifts on insert and
// delete, and registers one result per command.
// ----------------------------------------------------------------------------
module swt_ctrl
  import swt_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [OP_W-1:0]    in_kind,
  input  logic [KIND_W-1:0]  in_type_mask,
  input  logic [ADDR_W-1:0]  in_addr,
  input  logic [SPAN_W-1:0]  in_span,
  input  logic [ADDR_W-1:0]  limit,
  output mem_req_t           mreq,
  input  entry_t             rdata,
  output logic               out_valid,
  output logic [1:0]         out_status,
  output logic               out_hit,
  output logic [HIDX_W-1:0]  out_hit_index,
  output logic [KIND_W-1:0]  out_hit_kinds,
  output logic [1:0]         out_stop_reason,
  output logic [TOTAL_W-1:0] out_entry_total
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_RD    = 6'b000010,
    S_CHK   = 6'b000100,
    S_SH_RD = 6'b001000,
    S_SH_WR = 6'b010000,
    S_FIN   = 6'b100000
  } state_t;

  state_t             state_r, state_nxt;
  logic [OP_W-1:0]    op_r, op_nxt;
  logic [KIND_W-1:0]  tm_r, tm_nxt;
  logic [ADDR_W-1:0]  a_r, a_nxt;
  logic [SPAN_W-1:0]  sp_r, sp_nxt;
  logic [CNT_W-1:0]   cur_r, cur_nxt;
  logic [CNT_W-1:0]   pos_r, pos_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  status_t            status_r, status_nxt;
  logic               hit_r, hit_nxt;
  logic [HIDX_W-1:0]  hidx_r, hidx_nxt;
  logic [KIND_W-1:0]  hk_r, hk_nxt;
  reason_t            reason_r, reason_nxt;

  logic [CNT_W-1:0]   cur_m1;
  logic [CNT_W-1:0]   cur_p1;
  logic [SUM_W-1:0]   seg_end;
  logic               is_exact, is_above, is_cover, found, miss;
  logic [KIND_W-1:0]  kinds_rm;
  logic               is_set, limited;

  assign cur_m1   = cur_r - 1'b1;
  assign cur_p1   = cur_r + 1'b1;
  assign seg_end  = SUM_W'(rdata.addr) + SUM_W'(rdata.span);
  assign is_exact = (rdata.addr == a_r);
  assign is_above = (rdata.addr > a_r);
  assign is_cover = (SUM_W'(a_r) < seg_end);
  assign kinds_rm = rdata.kinds & ~tm_r;
  assign is_set   = (op_r == OP_SET);
  assign limited  = (in_kind == OP_SET || in_kind == OP_REMOVE) && (in_addr > limit);

  // Scan verdict for the entry returned this cycle
  always_comb begin
    if (op_r == OP_RANGE) begin
      found = !is_above && is_cover;
    end else begin
      found = is_exact;
    end
    miss = !found && is_above;
  end

  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    tm_nxt     = tm_r;
    a_nxt      = a_r;
    sp_nxt     = sp_r;
    cur_nxt    = cur_r;
    pos_nxt    = pos_r;
    count_nxt  = count_r;
    status_nxt = status_r;
    hit_nxt    = hit_r;
    hidx_nxt   = hidx_r;
    hk_nxt     = hk_r;
    reason_nxt = reason_r;
    mreq       = '0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt     = in_kind;
          a_nxt      = in_addr;
          sp_nxt     = in_span;
          tm_nxt     = in_type_mask;
          if (in_kind == OP_SET && in_type_mask == K_ACCESS) begin
            tm_nxt = in_type_mask | K_WRITE | K_READ;
          end
          cur_nxt    = '0;
          status_nxt = ST_OK;
          hit_nxt    = 1'b0;
          hidx_nxt   = '0;
          hk_nxt     = '0;
          reason_nxt = RSN_ACCESS;
          if (limited) begin
            status_nxt = ST_LIMIT;
            state_nxt  = S_FIN;
          end else begin
            case (in_kind)
              OP_SET, OP_REMOVE, OP_LOOKUP, OP_RANGE: state_nxt = S_RD;
              OP_CLEAR: begin
                count_nxt = '0;
                state_nxt = S_FIN;
              end
              default: state_nxt = S_FIN;
            endcase
          end
        end
      end

      S_RD: begin
        if (cur_r == count_r) begin
          // Ran off the end: miss with insertion point at the tail
          if (is_set) begin
            if (count_r == CNT_W'(TABLE_DEPTH)) begin
              status_nxt = ST_FULL;
              state_nxt  = S_FIN;
            end else begin
              pos_nxt   = cur_r;
              state_nxt = S_SH_RD;
            end
          end else begin
            status_nxt = ST_NOT_FOUND;
            state_nxt  = S_FIN;
          end
        end else begin
          mreq.re    = 1'b1;
          mreq.raddr = cur_r[IDX_W-1:0];
          state_nxt  = S_CHK;
        end
      end

      S_CHK: begin
        if (found) begin
          case (op_r)
            OP_SET: begin
              mreq.we    = 1'b1;
              mreq.waddr = cur_r[IDX_W-1:0];
              mreq.wdata = '{addr: a_r, span: sp_r, kinds: rdata.kinds | tm_r};
              state_nxt  = S_FIN;
            end
            OP_REMOVE: begin
              if (kinds_rm != '0) begin
                mreq.we    = 1'b1;
                mreq.waddr = cur_r[IDX_W-1:0];
                mreq.wdata = '{addr: rdata.addr, span: rdata.span, kinds: kinds_rm};
                state_nxt  = S_FIN;
              end else begin
                cur_nxt   = cur_p1;
                state_nxt = S_SH_RD;
              end
            end
            OP_LOOKUP: begin
              hit_nxt   = 1'b1;
              hidx_nxt  = HIDX_W'(cur_r);
              hk_nxt    = rdata.kinds;
              state_nxt = S_FIN;
            end
            default: begin
              if ((rdata.kinds & tm_r) != '0) begin
                hit_nxt  = 1'b1;
                hidx_nxt = HIDX_W'(cur_r);
                hk_nxt   = rdata.kinds;
                if ((rdata.kinds & K_ACCESS) != '0) begin
                  reason_nxt = RSN_ACCESS;
                end else if ((rdata.kinds & K_WRITE) != '0) begin
                  reason_nxt = RSN_WRITE;
                end else begin
                  reason_nxt = RSN_READ;
                end
              end
              state_nxt = S_FIN;
            end
          endcase
        end else if (miss) begin
          if (is_set) begin
            if (count_r == CNT_W'(TABLE_DEPTH)) begin
              status_nxt = ST_FULL;
              state_nxt  = S_FIN;
            end else begin
              pos_nxt   = cur_r;
              cur_nxt   = count_r;
              state_nxt = S_SH_RD;
            end
          end else begin
            status_nxt = ST_NOT_FOUND;
            state_nxt  = S_FIN;
          end
        end else begin
          cur_nxt   = cur_p1;
          state_nxt = S_RD;
        end
      end

      S_SH_RD: begin
        if (is_set) begin
          if (cur_r == pos_r) begin
            mreq.we    = 1'b1;
            mreq.waddr = pos_r[IDX_W-1:0];
            mreq.wdata = '{addr: a_r, span: sp_r, kinds: tm_r};
            count_nxt  = count_r + 1'b1;
            state_nxt  = S_FIN;
          end else begin
            mreq.re    = 1'b1;
            mreq.raddr = cur_m1[IDX_W-1:0];
            state_nxt  = S_SH_WR;
          end
        end else begin
          if (cur_r == count_r) begin
            count_nxt = count_r - 1'b1;
            state_nxt = S_FIN;
          end else begin
            mreq.re    = 1'b1;
            mreq.raddr = cur_r[IDX_W-1:0];
            state_nxt  = S_SH_WR;
          end
        end
      end

      S_SH_WR: begin
        mreq.we    = 1'b1;
        mreq.wdata = rdata;
        if (is_set) begin
          mreq.waddr = cur_r[IDX_W-1:0];
          cur_nxt    = cur_m1;
        end else begin
          mreq.waddr = cur_m1[IDX_W-1:0];
          cur_nxt    = cur_p1;
        end
        state_nxt = S_SH_RD;
      end

      S_FIN: begin
        state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    tm_r     <= tm_nxt;
    a_r      <= a_nxt;
    sp_r     <= sp_nxt;
    cur_r    <= cur_nxt;
    pos_r    <= pos_nxt;
    status_r <= status_nxt;
    hit_r    <= hit_nxt;
    hidx_r   <= hidx_nxt;
    hk_r     <= hk_nxt;
    reason_r <= reason_nxt;
  end

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = (state_r == S_FIN);
  assign out_status      = status_r;
  assign out_hit         = hit_r;
  assign out_hit_index   = hidx_r;
  assign out_hit_kinds   = hk_r;
  assign out_stop_reason = reason_r;
  assign out_entry_total = TOTAL_W'(count_r);

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(TABLE_DEPTH))
    else $error("entry count above table depth");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid && !busy)
    else $error("result strobe longer than one cycle");

  a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    !busy |-> !mreq.we && !mreq.re)
    else $error("entry store accessed while idle");

  a_hit_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> out_status == ST_OK)
    else $error("hit reported with failing status");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    busy && (count_r != $past(count_r)) |-> out_valid)
    else $error("entry count changed mid-command");
`endif

endmodule

FILE: rtl/sorted_watchpoint_table_top.sv
// ----------------------------------------------------------------------------
// sorted_watchpoint_table_top
// Address-sorted table of break and watch entries with set, remove, clear,
// exact lookup and range check commands.
//
// A command transfers on start while busy is low; busy stays high until its
// result has been shown. Each result appears for one cycle with out_valid and
// the receiver has no way to stall it, so it must take it on that cycle.
// cfg_we writes the address limit for set and remove; write only when idle.
// Steps: the scan reads and checks the entries in sorted order until a match
// or a larger address, or until it runs past the last entry; an insert then
// moves each entry above the insertion point up one slot, a delete moves each
// entry above the removed one down one slot, each move a read and then a
// write. Clear, limit rejects and unused codes go straight to the result. The
// entry store has one read port and one write port. After reset the table is
// empty and the limit is all ones; no clearing pass is needed.
// ----------------------------------------------------------------------------
module sorted_watchpoint_table_top
  import swt_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [OP_W-1:0]    in_kind,
  input  logic [KIND_W-1:0]  in_type_mask,
  input  logic [ADDR_W-1:0]  in_addr,
  input  logic [SPAN_W-1:0]  in_span,
  input  logic               cfg_we,
  input  logic [ADDR_W-1:0]  cfg_wdata,
  output logic               out_valid,
  output logic [1:0]         out_status,
  output logic               out_hit,
  output logic [HIDX_W-1:0]  out_hit_index,
  output logic [KIND_W-1:0]  out_hit_kinds,
  output logic [1:0]         out_stop_reason,
  output logic [TOTAL_W-1:0] out_entry_total
);

  // Address limit register: hold until the next configuration transfer
  logic [ADDR_W-1:0] limit_r, limit_nxt;

  assign limit_nxt = cfg_we ? cfg_wdata : limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= ADDR_MAX;
    end else begin
      limit_r <= limit_nxt;
    end
  end

  mem_req_t mreq;
  entry_t   rdata;

  // Sequencer: scan, merge, insert and delete through the entry store
  swt_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_kind         (in_kind),
    .in_type_mask    (in_type_mask),
    .in_addr         (in_addr),
    .in_span         (in_span),
    .limit           (limit_r),
    .mreq            (mreq),
    .rdata           (rdata),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_hit         (out_hit),
    .out_hit_index   (out_hit_index),
    .out_hit_kinds   (out_hit_kinds),
    .out_stop_reason (out_stop_reason),
    .out_entry_total (out_entry_total)
  );

  // Entry store: address, span and kinds of each sorted slot
  swt_ram u_ram (
    .clk   (clk),
    .req   (mreq),
    .rdata (rdata)
  );

endmodule

FILE: tb/sv/swt_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swt_result_checker
// Watches the command, configuration and result ports of the sorted
// watchpoint table. Keeps its own copy of the table, predicts the result of
// every accepted command and compares each result, field by field, with the
// oldest prediction still waiting.
// ----------------------------------------------------------------------------
module swt_result_checker
  import swt_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic [OP_W-1:0]    in_kind,
  input  logic [KIND_W-1:0]  in_type_mask,
  input  logic [ADDR_W-1:0]  in_addr,
  input  logic [SPAN_W-1:0]  in_span,
  input  logic               cfg_we,
  input  logic [ADDR_W-1:0]  cfg_wdata,
  input  logic               out_valid,
  input  logic [1:0]         out_status,
  input  logic               out_hit,
  input  logic [HIDX_W-1:0]  out_hit_index,
  input  logic [KIND_W-1:0]  out_hit_kinds,
  input  logic [1:0]         out_stop_reason,
  input  logic [TOTAL_W-1:0] out_entry_total,
  output int                 mismatches,
  output int                 outstanding
);

  typedef struct {
    status_t             status;
    logic                hit;
    logic [HIDX_W-1:0]   hit_index;
    logic [KIND_W-1:0]   hit_kinds;
    reason_t             stop_reason;
    logic [TOTAL_W-1:0]  entry_total;
  } wp_result_t;

  logic [ADDR_W-1:0] wp_addr  [TABLE_DEPTH];
  logic [SPAN_W-1:0] wp_span  [TABLE_DEPTH];
  logic [KIND_W-1:0] wp_kinds [TABLE_DEPTH];
  int                wp_count;
  logic [ADDR_W-1:0] limit_reg;
  wp_result_t        awaited_q[$];

  function automatic int find_exact_entry(input logic [ADDR_W-1:0] a);
    for (int i = 0; i < wp_count; i++) begin
      if (wp_addr[i] > a) return -1;
      if (wp_addr[i] == a) return i;
    end
    return -1;
  endfunction

  // Segment end is one bit wider so that entries near the top do not wrap.
  function automatic int find_cover_entry(input logic [ADDR_W-1:0] a);
    logic [SUM_W-1:0] seg_end;
    for (int i = 0; i < wp_count; i++) begin
      if (wp_addr[i] > a) return -1;
      seg_end = SUM_W'(wp_addr[i]) + SUM_W'(wp_span[i]);
      if (SUM_W'(a) < seg_end) return i;
    end
    return -1;
  endfunction

  function automatic wp_result_t apply_command(input logic [OP_W-1:0]   op,
                                               input logic [KIND_W-1:0] tm,
                                               input logic [ADDR_W-1:0] a,
                                               input logic [SPAN_W-1:0] sp);
    wp_result_t        r;
    int                idx;
    int                pos;
    logic [KIND_W-1:0] mask;
    r.status      = ST_OK;
    r.hit         = 1'b0;
    r.hit_index   = '0;
    r.hit_kinds   = '0;
    r.stop_reason = RSN_ACCESS;
    mask          = tm;
    case (op)
      OP_SET: begin
        if (a > limit_reg) begin
          r.status = ST_LIMIT;
        end else begin
          if (mask == K_ACCESS) mask = mask | K_WRITE | K_READ;
          idx = find_exact_entry(a);
          if (idx >= 0) begin
            wp_span[idx]  = sp;
            wp_kinds[idx] = wp_kinds[idx] | mask;
          end else if (wp_count >= TABLE_DEPTH) begin
            r.status = ST_FULL;
          end else begin
            pos = 0;
            while (pos < wp_count && wp_addr[pos] <= a) pos++;
            for (int j = wp_count; j > pos; j--) begin
              wp_addr[j]  = wp_addr[j-1];
              wp_span[j]  = wp_span[j-1];
              wp_kinds[j] = wp_kinds[j-1];
            end
            wp_addr[pos]  = a;
            wp_span[pos]  = sp;
            wp_kinds[pos] = mask;
            wp_count++;
          end
        end
      end
      OP_REMOVE: begin
        if (a > limit_reg) begin
          r.status = ST_LIMIT;
        end else begin
          idx = find_exact_entry(a);
          if (idx < 0) begin
            r.status = ST_NOT_FOUND;
          end else begin
            wp_kinds[idx] = wp_kinds[idx] & ~mask;
            if (wp_kinds[idx] == '0) begin
              for (int j = idx + 1; j < wp_count; j++) begin
                wp_addr[j-1]  = wp_addr[j];
                wp_span[j-1]  = wp_span[j];
                wp_kinds[j-1] = wp_kinds[j];
              end
              wp_count--;
            end
          end
        end
      end
      OP_CLEAR: begin
        wp_count = 0;
      end
      OP_LOOKUP: begin
        idx = find_exact_entry(a);
        if (idx < 0) begin
          r.status = ST_NOT_FOUND;
        end else begin
          r.hit       = 1'b1;
          r.hit_index = HIDX_W'(idx);
          r.hit_kinds = wp_kinds[idx];
        end
      end
      OP_RANGE: begin
        idx = find_cover_entry(a);
        if (idx < 0) begin
          r.status = ST_NOT_FOUND;
        end else if ((wp_kinds[idx] & mask) != '0) begin
          r.hit         = 1'b1;
          r.hit_index   = HIDX_W'(idx);
          r.hit_kinds   = wp_kinds[idx];
          r.stop_reason = ((wp_kinds[idx] & K_ACCESS) != '0) ? RSN_ACCESS :
                          ((wp_kinds[idx] & K_WRITE) != '0) ? RSN_WRITE : RSN_READ;
        end
      end
      default: begin
      end
    endcase
    r.entry_total = TOTAL_W'(wp_count);
    return r;
  endfunction

  task automatic check_field(input string field, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : track
    wp_result_t want;
    if (!rst_n) begin
      wp_count   = 0;
      limit_reg  = ADDR_MAX;
      mismatches = 0;
      awaited_q.delete();
    end else begin
      if (out_valid) begin
        if (awaited_q.size() == 0) begin
          $display("%0t: expected no result, got status %0d hit %0d total %0d",
                   $time, out_status, out_hit, out_entry_total);
          mismatches++;
        end else begin
          want = awaited_q.pop_front();
          check_field("status", want.status, out_status);
          check_field("hit", want.hit, out_hit);
          check_field("hit_index", want.hit_index, out_hit_index);
          check_field("hit_kinds", want.hit_kinds, out_hit_kinds);
          check_field("stop_reason", want.stop_reason, out_stop_reason);
          check_field("entry_total", want.entry_total, out_entry_total);
        end
      end
      if (start && !busy)
        awaited_q.push_back(apply_command(in_kind, in_type_mask, in_addr, in_span));
      if (cfg_we) limit_reg = cfg_wdata;
    end
    outstanding = awaited_q.size();
  end

endmodule

FILE: tb/sv/tb_sorted_watchpoint_table_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_watchpoint_table_top
// Drives commands and address-limit writes into the sorted watchpoint table
// and gives the verdict. A directed opening covers empty-table misses, access
// expansion, merges, covering entries without a shared kind, each stop reason,
// partial and full removal and the spare command codes. Random episodes then
// work on small address pools so the table fills, overflows and drains, under
// several address limits including zero and all ones. Checking is done by the
// result checker instantiated beside the block.
// ----------------------------------------------------------------------------
module tb_sorted_watchpoint_table_top;
  import swt_pkg::*;

  // Cycles without any transfer before the run is declared hung.
  localparam int STALL_LIMIT = 4000;
  // Pool of candidate addresses per episode; larger than the table on purpose
  // so that fill episodes run into the full condition.
  localparam int POOL_SLOTS  = 40;

  localparam logic [KIND_W-1:0] K_SOFT = 5'b00001;
  localparam logic [KIND_W-1:0] K_HARD = 5'b00010;

  logic               clk          = 1'b0;
  logic               rst_n        = 1'b0;
  logic               start        = 1'b0;
  logic [OP_W-1:0]    in_kind      = '0;
  logic [KIND_W-1:0]  in_type_mask = '0;
  logic [ADDR_W-1:0]  in_addr      = '0;
  logic [SPAN_W-1:0]  in_span      = '0;
  logic               cfg_we       = 1'b0;
  logic [ADDR_W-1:0]  cfg_wdata    = '0;

  logic               busy;
  logic               out_valid;
  logic [1:0]         out_status;
  logic               out_hit;
  logic [HIDX_W-1:0]  out_hit_index;
  logic [KIND_W-1:0]  out_hit_kinds;
  logic [1:0]         out_stop_reason;
  logic [TOTAL_W-1:0] out_entry_total;

  int mismatches;
  int outstanding;
  int stall_cycles = 0;
  int burst_left   = 1;

  always #5 clk = ~clk;

  sorted_watchpoint_table_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_kind         (in_kind),
    .in_type_mask    (in_type_mask),
    .in_addr         (in_addr),
    .in_span         (in_span),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_hit         (out_hit),
    .out_hit_index   (out_hit_index),
    .out_hit_kinds   (out_hit_kinds),
    .out_stop_reason (out_stop_reason),
    .out_entry_total (out_entry_total)
  );

  swt_result_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_kind         (in_kind),
    .in_type_mask    (in_type_mask),
    .in_addr         (in_addr),
    .in_span         (in_span),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_hit         (out_hit),
    .out_hit_index   (out_hit_index),
    .out_hit_kinds   (out_hit_kinds),
    .out_stop_reason (out_stop_reason),
    .out_entry_total (out_entry_total),
    .mismatches      (mismatches),
    .outstanding     (outstanding)
  );

  // Watchdog: count cycles in which neither a command nor a result transfers.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid)
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Present one command from a falling edge and hold it until it transfers.
  // Afterwards, close the burst if it is used up and idle for a random gap.
  task automatic issue(input logic [OP_W-1:0]   op,
                       input logic [KIND_W-1:0] tm,
                       input logic [ADDR_W-1:0] a,
                       input logic [SPAN_W-1:0] sp);
    int gap;
    start        = 1'b1;
    in_kind      = op;
    in_type_mask = tm;
    in_addr      = a;
    in_span      = sp;
    do @(posedge clk); while (busy);
    @(negedge clk);
    burst_left--;
    if (burst_left <= 0) begin
      gap        = $urandom_range(0, 8);
      burst_left = $urandom_range(1, 16);
      if (gap > 0) begin
        start = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  // Drop start and hold off until every expected result has come back and
  // the block has gone idle, plus a short margin.
  task automatic settle();
    start = 1'b0;
    while (outstanding != 0 || busy) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_limit(input logic [ADDR_W-1:0] value);
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  // Random episodes. Each one picks a flavour (fill, drain or mixed), an
  // address pool and a stride, then issues mostly well-formed commands on that
  // pool; a small share is noise over the whole input space.
  task automatic run_phase(input int items);
    int                issued;
    int                ep_len;
    int                stride;
    int                r;
    int                set_cut;
    int                rem_cut;
    int                look_cut;
    int                base_max;
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] a;
    logic [KIND_W-1:0] tm;
    logic [SPAN_W-1:0] sp;
    logic [OP_W-1:0]   op;
    issued = 0;
    while (issued < items) begin
      case ($urandom_range(0, 2))
        0: begin            // fill
          set_cut = 60; rem_cut = 70; look_cut = 80;
        end
        1: begin            // drain
          set_cut = 15; rem_cut = 65; look_cut = 78;
        end
        default: begin      // mixed
          set_cut = 30; rem_cut = 55; look_cut = 72;
        end
      endcase
      case ($urandom_range(0, 3))
        0:       stride = 1;
        1:       stride = 4;
        2:       stride = 16;
        default: stride = 256;
      endcase
      base_max = (1 << ADDR_W) - 1 - (POOL_SLOTS - 1) * stride;
      case ($urandom_range(0, 9))
        0:       base = '0;
        1:       base = ADDR_W'(base_max);
        default: base = ADDR_W'($urandom_range(0, base_max));
      endcase
      ep_len = $urandom_range(20, 80);
      if (ep_len > items - issued) ep_len = items - issued;
      repeat (ep_len) begin
        r  = $urandom_range(0, 99);
        a  = base + ADDR_W'($urandom_range(0, POOL_SLOTS - 1) * stride);
        tm = KIND_W'($urandom);
        case ($urandom_range(0, 9))
          0:       sp = '0;
          1:       sp = '1;
          2, 3:    sp = SPAN_W'($urandom);
          default: sp = SPAN_W'($urandom_range(1, 3 * stride));
        endcase
        if (r < set_cut) begin
          op = OP_SET;
          if ($urandom_range(0, 3) == 0) tm = K_ACCESS;
        end else if (r < rem_cut) begin
          op = OP_REMOVE;
          if ($urandom_range(0, 2) == 0) tm = '1;
        end else if (r < look_cut) begin
          op = OP_LOOKUP;
        end else if (r < 95) begin
          // Probe inside or just past the watched segments.
          op = OP_RANGE;
          a  = a + ADDR_W'($urandom_range(0, 2 * stride));
        end else if (r == 95) begin
          op = OP_CLEAR;
        end else if (r == 96) begin
          op = OP_W'(OP_RANGE + $urandom_range(1, 3));
        end else begin
          op = OP_W'($urandom_range(0, 7));
          a  = ADDR_W'($urandom);
          sp = SPAN_W'($urandom);
        end
        issue(op, tm, a, sp);
        issued++;
      end
    end
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // Misses on an empty table.
    issue(OP_LOOKUP, '0, 24'h000000, '0);
    issue(OP_RANGE, 5'h1F, 24'h000000, '0);
    issue(OP_REMOVE, 5'h1F, 24'h000005, '0);
    // Access-only set expands to write and read; empty mask still creates.
    issue(OP_SET, K_ACCESS, 24'h000100, 16'h0010);
    issue(OP_SET, '0, 24'h000000, 16'h0000);
    issue(OP_SET, 5'h1F, ADDR_MAX, 16'hFFFF);
    // Merge into an existing entry and overwrite its span.
    issue(OP_SET, K_SOFT | K_HARD, 24'h000100, 16'h0020);
    issue(OP_LOOKUP, '0, 24'h000100, '0);
    issue(OP_LOOKUP, '0, 24'h000000, '0);
    issue(OP_RANGE, K_WRITE, 24'h000110, '0);
    // Zero-span entry covers nothing.
    issue(OP_RANGE, 5'h1F, 24'h000000, '0);
    // Top entry whose segment runs past the address space.
    issue(OP_RANGE, K_HARD, ADDR_MAX, '0);
    issue(OP_RANGE, K_SOFT, 24'h000150, '0);
    // Covering entry without a shared kind, then write and read reasons.
    issue(OP_SET, K_WRITE, 24'h000200, 16'h0008);
    issue(OP_RANGE, K_ACCESS, 24'h000204, '0);
    issue(OP_RANGE, K_WRITE, 24'h000204, '0);
    issue(OP_SET, K_READ, 24'h000300, 16'h0001);
    issue(OP_RANGE, K_READ, 24'h000300, '0);
    // Partial removal, full removal, and removal of a kind-less entry.
    issue(OP_REMOVE, K_ACCESS, 24'h000100, '0);
    issue(OP_REMOVE, 5'h1F, 24'h000100, '0);
    issue(OP_REMOVE, '0, 24'h000000, '0);
    for (int c = OP_RANGE + 1; c < (1 << OP_W); c++)
      issue(OP_W'(c), 5'h1F, ADDR_MAX, 16'hFFFF);
    issue(OP_CLEAR, '0, '0, '0);
    issue(OP_LOOKUP, '0, ADDR_MAX, '0);

    // Random phases under a range of address limits.
    settle();
    write_limit(24'h800000);
    run_phase(250);
    settle();
    write_limit('0);
    run_phase(150);
    settle();
    write_limit(ADDR_W'($urandom_range(1, 24'hFFFFFE)));
    run_phase(250);
    settle();
    write_limit(ADDR_MAX);
    run_phase(430);

    // Wait out any late or stray result before the verdict.
    settle();
    repeat (20) @(negedge clk);
    if (mismatches == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
